// ===== rtl/core/angle_unwrap_velocity_macros.svh =====
// Assertion macros shared by the angle unwrap and velocity RTL.
`ifndef ANGLE_UNWRAP_VELOCITY_MACROS_SVH
`define ANGLE_UNWRAP_VELOCITY_MACROS_SVH

// Same-cycle implication, sampled on i_clk and ignored while i_rst_n is low.
`define AUV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("auv assertion failed");

// Next-cycle implication, sampled on i_clk and ignored while i_rst_n is low.
`define AUV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("auv assertion failed");

`endif

// ===== rtl/core/auv_pkg.sv =====
// Shared types and constants of the angle unwrap and velocity block.
package auv_pkg;

    localparam int RAW_BITS_DEF   = 12;
    localparam int TOTAL_BITS_DEF = 32;

    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int TDATA_IN_W  = 48;
    localparam int TUSER_IN_W  = 3;
    localparam int TDATA_OUT_W = 80;
    localparam int TUSER_OUT_W = 2;

    localparam int US_PER_S_W = 20;
    localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;

    localparam logic [CFG_DATA_W-1:0] MAX_INTERVAL_RST = 32'd100000;
    localparam logic [CFG_DATA_W-1:0] FALLBACK_RST     = 32'd100;

    typedef enum logic [1:0] {
        REQ_UPDATE     = 2'd0,
        REQ_VELOCITY   = 2'd1,
        REQ_ZERO       = 2'd2,
        REQ_UPDATE_ALT = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_VEL  = 2'd1,
        ST_ZERO_DT = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_INTERVAL = 1'b0,
        REG_FALLBACK     = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_MULT,
        S_DIVIDE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic apply;
        logic zero;
    } t_unwrap_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== rtl/core/auv_unwrap.sv =====
// Multi-turn angle state: unwrap across the half turn and saturating total.
module auv_unwrap #(
    parameter int RAW_BITS   = auv_pkg::RAW_BITS_DEF,
    parameter int TOTAL_BITS = auv_pkg::TOTAL_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  auv_pkg::t_unwrap_cmd       i_cmd,
    input  logic [RAW_BITS-1:0]        i_raw,
    input  logic                       i_read_ok,
    output logic [RAW_BITS-1:0]        o_prev_raw,
    output logic [TOTAL_BITS-1:0]      o_total,
    output logic signed [RAW_BITS:0]   o_change
);
    import auv_pkg::*;

    localparam int CHG_W  = RAW_BITS + 1;
    localparam int EXT_W  = (TOTAL_BITS > RAW_BITS) ? TOTAL_BITS + 1 : RAW_BITS + 1;
    localparam int HALF_I = 1 << (RAW_BITS - 1);
    localparam logic signed [RAW_BITS+1:0] HALF = (RAW_BITS + 2)'(HALF_I);
    localparam logic signed [RAW_BITS+1:0] FULL = (RAW_BITS + 2)'(2 * HALF_I);
    localparam logic [TOTAL_BITS-1:0] MX = {1'b0, {(TOTAL_BITS - 1){1'b1}}};
    localparam logic [TOTAL_BITS-1:0] MN = {1'b1, {(TOTAL_BITS - 1){1'b0}}};

    logic [RAW_BITS-1:0]        r_prev_raw, n_prev_raw;
    logic [TOTAL_BITS-1:0]      r_total, n_total;
    logic                       r_known, n_known;

    logic signed [RAW_BITS+1:0] w_dd;
    logic signed [CHG_W-1:0]    w_d;
    logic [TOTAL_BITS:0]        w_sum;
    logic                       w_ovf_hi, w_ovf_lo;
    logic                       w_raw_big;
    logic signed [CHG_W-1:0]    w_change;

    always_comb begin
        // Raw difference, folded into [-half, half] turns.
        w_dd = (RAW_BITS + 2)'($signed({1'b0, i_raw})) - (RAW_BITS + 2)'($signed({1'b0, r_prev_raw}));
        if (w_dd > HALF) begin
            w_dd = w_dd - FULL;
        end else if (w_dd < -HALF) begin
            w_dd = w_dd + FULL;
        end
        w_d = w_dd[CHG_W-1:0];

        w_sum    = {r_total[TOTAL_BITS-1], r_total} + (TOTAL_BITS + 1)'(w_d);
        w_ovf_hi = (w_sum[TOTAL_BITS] != w_sum[TOTAL_BITS-1]) && !w_sum[TOTAL_BITS];
        w_ovf_lo = (w_sum[TOTAL_BITS] != w_sum[TOTAL_BITS-1]) && w_sum[TOTAL_BITS];
        w_raw_big = EXT_W'(i_raw) > EXT_W'(MX);
    end

    always_comb begin
        n_prev_raw = r_prev_raw;
        n_total    = r_total;
        n_known    = r_known;
        w_change   = '0;
        if (i_cmd.zero) begin
            n_total    = '0;
            n_prev_raw = i_read_ok ? i_raw : '0;
        end else if (i_cmd.apply) begin
            n_prev_raw = i_raw;
            if (!r_known) begin
                // The total is zero until the first good sample, so the change is the load value.
                n_known  = 1'b1;
                n_total  = w_raw_big ? MX : TOTAL_BITS'(i_raw);
                w_change = w_raw_big ? CHG_W'(MX) : CHG_W'(i_raw);
            end else if (w_ovf_hi) begin
                n_total  = MX;
                w_change = CHG_W'(MX - r_total);
            end else if (w_ovf_lo) begin
                n_total  = MN;
                w_change = CHG_W'(MN - r_total);
            end else begin
                n_total  = w_sum[TOTAL_BITS-1:0];
                w_change = w_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= '0;
            r_total    <= '0;
            r_known    <= 1'b0;
        end else begin
            r_prev_raw <= n_prev_raw;
            r_total    <= n_total;
            r_known    <= n_known;
        end
    end

    assign o_prev_raw = r_prev_raw;
    assign o_total    = r_total;
    assign o_change   = w_change;

endmodule

// ===== rtl/core/auv_divider.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
`include "angle_unwrap_velocity_macros.svh"

module auv_divider #(
    parameter int DVD_W = 33,
    parameter int DVS_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVD_W-1:0]     i_dividend,
    input  logic [DVS_W-1:0]     i_divisor,
    output logic [DVD_W-1:0]     o_quotient,
    output auv_pkg::t_div_status o_status
);
    import auv_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_fits;

    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_diff  = w_shift - {1'b0, i_divisor};
        w_fits  = !w_diff[DVS_W];
        n_rem   = w_fits ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
        n_quo   = {r_quo[DVD_W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    `AUV_ASSERT_NOW(a_no_start_while_busy, i_start, !r_busy)
    `AUV_ASSERT_NEXT(a_start_runs, i_start, r_busy && !r_done)
    `AUV_ASSERT_NOW(a_rem_below_divisor, r_busy, r_rem < i_divisor)

endmodule

// ===== rtl/core/angle_unwrap_velocity.sv =====
// Top level: multi-turn angle unwrap with velocity in counts per second.
// One item is in work at a time: a new sample is taken only after the last result is loaded
// into the output register. Update and zero requests pass through APPLY and RESULT; a velocity
// request adds MULT and, for a nonzero interval, DIVIDE, where the divider yields one quotient
// bit a cycle. Reset (i_rst_n low, synchronous) clears the angle state and the time stamp and
// reloads both register defaults.
`include "angle_unwrap_velocity_macros.svh"

module angle_unwrap_velocity #(
    parameter int RAW_BITS   = auv_pkg::RAW_BITS_DEF,
    parameter int TOTAL_BITS = auv_pkg::TOTAL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Sample stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // raw_high_byte[7:0], raw_low_byte[15:8], timestamp_us[47:16]
    input  logic [auv_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // req_type[1:0], read_ok[2]
    input  logic [auv_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // total_angle[31:0], last_raw[43:32], velocity[75:44], zero fill[79:76]
    output logic [auv_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [auv_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
    // Configuration writes: index 0 max_interval_us, index 1 fallback_interval_us.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [auv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [auv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import auv_pkg::*;

    // The change per sample is at most one turn, so the scaled dividend stays narrow.
    localparam int CHG_W  = RAW_BITS + 1;
    localparam int DVD_W  = CHG_W + US_PER_S_W;
    localparam int QX_W   = (DVD_W > 33) ? DVD_W : 33;
    localparam int TX_W   = (TOTAL_BITS > 32) ? TOTAL_BITS : 32;
    localparam int RX_W   = (RAW_BITS > 12) ? RAW_BITS : 12;
    localparam logic [QX_W-1:0] POS_LIMIT = QX_W'(33'h0_7FFF_FFFF);
    localparam logic [QX_W-1:0] NEG_LIMIT = QX_W'(33'h0_8000_0000);

    // Sequencer state and control registers.
    t_state                r_state, n_state;
    logic                  r_out_valid;
    logic [TIME_W-1:0]     r_prev_time;
    logic [CFG_DATA_W-1:0] r_max_interval;
    logic [CFG_DATA_W-1:0] r_fallback;

    // Item being worked on.
    t_req                  r_req;
    logic [RAW_BITS-1:0]   r_raw;
    logic                  r_ok;
    logic [TIME_W-1:0]     r_ts;
    logic [TIME_W-1:0]     r_dt;
    logic signed [CHG_W-1:0] r_change;
    logic                  r_neg;
    logic                  r_use_div;
    t_status               r_status;
    logic [TDATA_OUT_W-1:0] r_out_data;
    logic [TUSER_OUT_W-1:0] r_out_user;

    // Sequencer outputs.
    logic                  w_in_ready;
    t_unwrap_cmd           w_cmd;
    logic                  w_div_start;
    logic                  w_out_load;

    // Datapath wires.
    logic                  w_accept;
    logic [15:0]           w_raw_word;
    logic [TIME_W-1:0]     w_dt_raw;
    logic [TIME_W-1:0]     n_dt;
    logic [CHG_W-1:0]      w_mag;
    logic [DVD_W-1:0]      w_product;
    logic [DVD_W-1:0]      w_quotient;
    t_div_status           w_div_status;
    logic [QX_W-1:0]       w_q_ext;
    logic [31:0]           w_velocity;
    t_status               w_status;
    logic [RAW_BITS-1:0]   w_prev_raw;
    logic [TOTAL_BITS-1:0] w_total;
    logic signed [CHG_W-1:0] w_change;
    logic signed [TX_W-1:0]  w_total_x;
    logic [RX_W-1:0]       w_prev_raw_x;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_raw_word = {s_axis_tdata[7:0], s_axis_tdata[15:8]};

    // The registers take writes at any time; software must write them only while idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_interval <= MAX_INTERVAL_RST;
            r_fallback     <= FALLBACK_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_MAX_INTERVAL: r_max_interval <= i_cfg_data;
                REG_FALLBACK:     r_fallback     <= i_cfg_data;
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = (r_req == REQ_VELOCITY) ? S_MULT : S_RESULT;
            end
            S_MULT: begin
                n_state = (r_dt == '0) ? S_RESULT : S_DIVIDE;
            end
            S_DIVIDE: begin
                if (w_div_status.done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        w_in_ready  = 1'b0;
        w_cmd       = '0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_APPLY: begin
                w_cmd.zero  = (r_req == REQ_ZERO);
                w_cmd.apply = r_ok && (r_req != REQ_ZERO);
            end
            S_MULT: begin
                w_div_start = (r_dt != '0);
            end
            S_DIVIDE: begin
                w_in_ready = 1'b0;
            end
            S_RESULT: begin
                w_out_load = !r_out_valid || m_axis_tready;
            end
        endcase
    end

    assign s_axis_tready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Angle state: unwrap and saturate in the apply cycle.
    auv_unwrap #(
        .RAW_BITS   (RAW_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_unwrap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_raw      (r_raw),
        .i_read_ok  (r_ok),
        .o_prev_raw (w_prev_raw),
        .o_total    (w_total),
        .o_change   (w_change)
    );

    // Interval since the previous velocity request, modulo the timer width; above max_interval the fallback is used.
    always_comb begin
        w_dt_raw = r_ts - r_prev_time;
        n_dt     = (w_dt_raw > r_max_interval) ? r_fallback : w_dt_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
        end else if (r_state == S_APPLY && r_req == REQ_VELOCITY) begin
            r_prev_time <= r_ts;
        end
    end

    // Magnitude of the change times one million, loaded straight into the divider.
    assign w_mag     = r_change[CHG_W-1] ? CHG_W'(-r_change) : CHG_W'(r_change);
    assign w_product = DVD_W'(w_mag) * DVD_W'(US_PER_S);

    auv_divider #(
        .DVD_W (DVD_W),
        .DVS_W (TIME_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_product),
        .i_divisor  (r_dt),
        .o_quotient (w_quotient),
        .o_status   (w_div_status)
    );

    // Signed result from the magnitude quotient, truncated toward zero, then clamped.
    always_comb begin
        w_q_ext    = QX_W'(w_quotient);
        w_velocity = '0;
        w_status   = r_status;
        if (r_use_div) begin
            w_status = ST_OK;
            if (r_neg) begin
                if (w_q_ext > NEG_LIMIT) begin
                    w_velocity = 32'h8000_0000;
                    w_status   = ST_SAT;
                end else begin
                    w_velocity = 32'd0 - w_q_ext[31:0];
                end
            end else begin
                if (w_q_ext > POS_LIMIT) begin
                    w_velocity = 32'h7FFF_FFFF;
                    w_status   = ST_SAT;
                end else begin
                    w_velocity = w_q_ext[31:0];
                end
            end
        end
    end

    assign w_total_x    = TX_W'($signed(w_total));
    assign w_prev_raw_x = RX_W'(w_prev_raw);

    // Payload registers along the sequence; the sequencer decides when each is meaningful.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req'(s_axis_tuser[1:0]);
            r_ok  <= s_axis_tuser[2];
            r_raw <= w_raw_word[RAW_BITS-1:0];
            r_ts  <= s_axis_tdata[47:16];
        end
        if (r_state == S_APPLY) begin
            r_dt      <= n_dt;
            r_change  <= w_cmd.apply ? w_change : '0;
            r_use_div <= 1'b0;
            r_status  <= ST_NO_VEL;
        end
        if (r_state == S_MULT) begin
            r_neg     <= r_change[CHG_W-1];
            r_use_div <= (r_dt != '0);
            r_status  <= (r_dt == '0) ? ST_ZERO_DT : ST_OK;
        end
        if (w_out_load) begin
            r_out_data <= {4'b0000, w_velocity, w_prev_raw_x[11:0], w_total_x[31:0]};
            r_out_user <= w_status;
        end
    end

    // Output register: holds one finished transaction until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `AUV_ASSERT_NOW(a_divide_only_velocity, r_state == S_DIVIDE, r_req == REQ_VELOCITY)
    `AUV_ASSERT_NOW(a_divide_nonzero_dt, r_state == S_DIVIDE, r_dt != '0)
    `AUV_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

// ===== sim/tb_angle_unwrap_velocity.sv =====
// Self-checking testbench for the multi-turn angle unwrap and velocity block.
module tb_angle_unwrap_velocity;
    timeunit 1ns;
    timeprecision 1ps;

    import auv_pkg::*;

    localparam int          HI_BITS       = RAW_BITS_DEF - 8;
    localparam int          FULL_TURN     = 1 << RAW_BITS_DEF;
    localparam int          HALF_TURN     = FULL_TURN / 2;
    localparam longint      TOTAL_MAX     = (longint'(1) << (TOTAL_BITS_DEF - 1)) - 1;
    localparam longint      TOTAL_MIN     = -TOTAL_MAX - 1;
    localparam longint      RATE_MAX      = 64'sd2147483647;
    localparam longint      RATE_MIN      = -64'sd2147483648;
    localparam int          IDLE_PCT      = 32;
    localparam int          PHASE_SAMPLES = 226;
    localparam int          SETTLE_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    // What the driver works through: a sensor sample, a register write, or a
    // hold until every outstanding result has come back.
    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_CFG,
        OP_HOLD
    } t_op_kind;

    typedef struct {
        t_op_kind      kind;
        t_req          req;
        logic [7:0]    hi;
        logic [7:0]    lo;
        logic          ok;
        logic [31:0]   ts;
        logic          calm;
        t_cfg_reg      reg_idx;
        logic [31:0]   value;
    } t_stim_op;

    typedef struct {
        logic signed [31:0]     total;
        logic [RAW_BITS_DEF-1:0] raw;
        logic signed [31:0]     vel;
        t_status                status;
    } t_reading;

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_IN_W-1:0]   s_axis_tdata  = '0;
    logic [TUSER_IN_W-1:0]   s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_axis_tdata;
    logic [TUSER_OUT_W-1:0]  m_axis_tuser;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    angle_unwrap_velocity u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    t_stim_op    pending_ops[$];
    t_reading    expected_readings[$];
    int          samples_queued = 0;
    int          results_seen   = 0;
    int          error_count    = 0;
    int unsigned cycle_count    = 0;

    // Handshake flags seen at the last rising edge, read by the driver at the
    // following falling edge.
    logic        sample_fire = 1'b0;
    logic        cfg_fire    = 1'b0;
    // Set while the current sample belongs to the stretch with no idling.
    logic        calm        = 1'b0;

    // Stimulus-side memory of the last raw angle and timestamp, so that the
    // random samples move like a real rotating shaft most of the time.
    logic [RAW_BITS_DEF-1:0] gen_raw;
    logic [31:0]             gen_ts;

    // Tracker state: our own copy of the unwrapper, the timestamp of the last
    // velocity request and both interval registers.
    logic [RAW_BITS_DEF-1:0] trk_raw;
    logic signed [31:0]      trk_total;
    logic                    trk_known;
    logic [31:0]             trk_time;
    logic [31:0]             lim_interval;
    logic [31:0]             fb_interval;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Unwraps one good raw angle into the running total. Returns the change
    // that was actually applied, after saturation.
    function automatic longint unwrap_into_total(input logic [RAW_BITS_DEF-1:0] raw);
        longint old_total;
        longint new_total;
        int     step;
        old_total = trk_total;
        if (!trk_known) begin
            // The first good sample loads the total directly.
            new_total = longint'(raw);
            if (new_total > TOTAL_MAX)
                new_total = TOTAL_MAX;
            trk_known = 1'b1;
        end else begin
            step = int'(raw) - int'(trk_raw);
            // Exactly half a turn keeps the sign of the raw difference.
            if (step > HALF_TURN)
                step -= FULL_TURN;
            else if (step < -HALF_TURN)
                step += FULL_TURN;
            new_total = old_total + step;
            if (new_total > TOTAL_MAX)
                new_total = TOTAL_MAX;
            else if (new_total < TOTAL_MIN)
                new_total = TOTAL_MIN;
        end
        trk_total = new_total[31:0];
        trk_raw   = raw;
        return new_total - old_total;
    endfunction

    function automatic t_reading predict_reading(input t_req req,
                                                 input logic [RAW_BITS_DEF-1:0] raw,
                                                 input logic ok, input logic [31:0] ts);
        t_reading r;
        longint   change;
        longint   rate;
        logic [31:0] dt;
        rate     = 0;
        r.status = ST_NO_VEL;
        case (req)
            REQ_ZERO: begin
                // Zeroing keeps the first-sample flag and the velocity timestamp.
                trk_total = '0;
                trk_raw   = ok ? raw : '0;
            end
            REQ_VELOCITY: begin
                change = ok ? unwrap_into_total(raw) : 0;
                dt     = ts - trk_time;
                if (dt > lim_interval)
                    dt = fb_interval;
                trk_time = ts;
                if (dt == '0) begin
                    r.status = ST_ZERO_DT;
                end else begin
                    rate     = (change * longint'(US_PER_S)) / longint'({32'd0, dt});
                    r.status = ST_OK;
                    if (rate > RATE_MAX) begin
                        rate     = RATE_MAX;
                        r.status = ST_SAT;
                    end else if (rate < RATE_MIN) begin
                        rate     = RATE_MIN;
                        r.status = ST_SAT;
                    end
                end
            end
            default: begin
                // The unused code behaves as a plain update.
                if (ok)
                    void'(unwrap_into_total(raw));
            end
        endcase
        r.total = trk_total;
        r.raw   = trk_raw;
        r.vel   = rate[31:0];
        return r;
    endfunction

    function automatic void push_sample(input t_req req, input logic [7:0] hi,
                                        input logic [7:0] lo, input logic ok,
                                        input logic [31:0] ts, input logic calm_flag);
        t_stim_op op;
        op.kind    = OP_SAMPLE;
        op.req     = req;
        op.hi      = hi;
        op.lo      = lo;
        op.ok      = ok;
        op.ts      = ts;
        op.calm    = calm_flag;
        op.reg_idx = REG_MAX_INTERVAL;
        op.value   = '0;
        pending_ops.push_back(op);
        samples_queued++;
    endfunction

    function automatic void push_hold();
        t_stim_op op;
        op.kind    = OP_HOLD;
        op.req     = REQ_UPDATE;
        op.hi      = '0;
        op.lo      = '0;
        op.ok      = 1'b0;
        op.ts      = '0;
        op.calm    = 1'b0;
        op.reg_idx = REG_MAX_INTERVAL;
        op.value   = '0;
        pending_ops.push_back(op);
    endfunction

    // Register writes only happen once the block has drained.
    function automatic void push_cfg(input t_cfg_reg idx, input logic [31:0] value);
        t_stim_op op;
        push_hold();
        op         = pending_ops[$];
        op.kind    = OP_CFG;
        op.reg_idx = idx;
        op.value   = value;
        pending_ops.push_back(op);
    endfunction

    // Random samples. Most follow the shaft with small or half-turn-sized steps,
    // the rest jump anywhere. Samples calm_lo..calm_hi run with no idling.
    task automatic push_random_samples(input int count, input int calm_lo, input int calm_hi);
        int         pick;
        int         step;
        t_req       req;
        logic [7:0] hi;
        logic       ok;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 55)
                step = int'($urandom_range(200)) - 100;
            else if (pick < 75)
                step = int'($urandom_range(4200)) - 2100;
            else if (pick < 85)
                step = $urandom_range(1) ? HALF_TURN : -HALF_TURN;
            else
                step = $urandom_range(FULL_TURN - 1);
            gen_raw = gen_raw + step[RAW_BITS_DEF-1:0];

            pick = $urandom_range(99);
            if (pick < 10)
                gen_ts = gen_ts;
            else if (pick < 45)
                gen_ts = gen_ts + $urandom_range(50, 1);
            else if (pick < 80)
                gen_ts = gen_ts + $urandom_range(150000, 1);
            else
                gen_ts = gen_ts + $urandom();

            pick = $urandom_range(99);
            if (pick < 40)
                req = REQ_UPDATE;
            else if (pick < 82)
                req = REQ_VELOCITY;
            else if (pick < 91)
                req = REQ_ZERO;
            else
                req = REQ_UPDATE_ALT;

            hi      = $urandom_range(255);
            hi[HI_BITS-1:0] = gen_raw[RAW_BITS_DEF-1:8];
            ok      = ($urandom_range(99) < 90);
            push_sample(req, hi, gen_raw[7:0], ok, gen_ts, (n >= calm_lo) && (n <= calm_hi));
            // Now and then the sender waits until every result is back.
            if ($urandom_range(99) == 0)
                push_hold();
        end
    endtask

    // Driver: changes inputs at the falling edge. A sample or a register write
    // stays on the bus until its transaction completes.
    always @(negedge i_clk) begin : driver
        t_stim_op op;
        logic     take;
        op.kind = OP_HOLD;
        take    = 1'b0;
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
        end else if (!(s_axis_tvalid && !sample_fire) && !(i_cfg_valid && !cfg_fire)) begin
            if (pending_ops.size() != 0) begin
                case (pending_ops[0].kind)
                    OP_HOLD:   take = (expected_readings.size() == 0);
                    OP_CFG:    take = 1'b1;
                    default:   take = pending_ops[0].calm || ($urandom_range(99) >= IDLE_PCT);
                endcase
            end
            if (take)
                op = pending_ops.pop_front();
            s_axis_tvalid <= take && (op.kind == OP_SAMPLE);
            i_cfg_valid   <= take && (op.kind == OP_CFG);
            if (take && op.kind == OP_SAMPLE) begin
                s_axis_tdata <= {op.ts, op.lo, op.hi};
                s_axis_tuser <= {op.ok, op.req};
                calm         = op.calm;
            end
            if (take && op.kind == OP_CFG) begin
                i_cfg_index <= op.reg_idx;
                i_cfg_data  <= op.value;
            end
        end
    end

    // Monitor: samples every handshake at the rising edge, keeps the tracker in
    // step with accepted samples and register writes, and checks each result
    // against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_reading                got;
        t_reading                want;
        logic [RAW_BITS_DEF-1:0] raw;
        sample_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        cfg_fire    = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            trk_raw      = '0;
            trk_total    = '0;
            trk_known    = 1'b0;
            trk_time     = '0;
            lim_interval = MAX_INTERVAL_RST;
            fb_interval  = FALLBACK_RST;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.total  = m_axis_tdata[31:0];
                got.raw    = m_axis_tdata[43:32];
                got.vel    = m_axis_tdata[75:44];
                got.status = t_status'(m_axis_tuser[1:0]);
                if (expected_readings.size() == 0) begin
                    report_error("result transaction with nothing expected");
                end else begin
                    want = expected_readings.pop_front();
                    if (got.total !== want.total)
                        report_error($sformatf("total_angle expected %0d got %0d",
                                               want.total, got.total));
                    if (got.raw !== want.raw)
                        report_error($sformatf("last_raw expected %0d got %0d",
                                               want.raw, got.raw));
                    if (got.vel !== want.vel)
                        report_error($sformatf("velocity expected %0d got %0d",
                                               want.vel, got.vel));
                    if (got.status !== want.status)
                        report_error($sformatf("status expected %s got %0d",
                                               want.status.name(), m_axis_tuser));
                end
            end
            if (cfg_fire) begin
                if (i_cfg_index == REG_MAX_INTERVAL)
                    lim_interval = i_cfg_data;
                else
                    fb_interval = i_cfg_data;
            end
            if (sample_fire) begin
                raw = {s_axis_tdata[HI_BITS-1:0], s_axis_tdata[15:8]};
                expected_readings.push_back(predict_reading(t_req'(s_axis_tuser[1:0]), raw,
                                                            s_axis_tuser[2],
                                                            s_axis_tdata[47:16]));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        gen_raw = '0;
        gen_ts  = '0;

        // Reset register values. A failed read before any good sample, then a
        // first sample at full scale one microsecond in, which saturates the rate.
        push_sample(REQ_UPDATE,     8'h00, 8'h00, 1'b0, 32'd0, 1'b0);
        push_sample(REQ_VELOCITY,   8'hFF, 8'hFF, 1'b1, 32'd1, 1'b0);
        // Same timestamp again: zero interval.
        push_sample(REQ_VELOCITY,   8'h0F, 8'hFF, 1'b1, 32'd1, 1'b0);
        // Unused request code as an update, wrapping forward across zero.
        push_sample(REQ_UPDATE_ALT, 8'h00, 8'h00, 1'b1, 32'd5, 1'b0);
        // Exactly half a turn forward, then exactly half a turn back.
        push_sample(REQ_UPDATE,     8'h08, 8'h00, 1'b1, 32'd5, 1'b0);
        push_sample(REQ_UPDATE,     8'h00, 8'h00, 1'b1, 32'd5, 1'b0);
        // Just past half a turn unwraps backward: large negative rate.
        push_sample(REQ_VELOCITY,   8'h08, 8'h01, 1'b1, 32'd2, 1'b0);
        // Interval one above the limit uses the fallback; failed read, no change.
        push_sample(REQ_VELOCITY,   8'h33, 8'hCC, 1'b0, 32'd100003, 1'b0);
        // Interval exactly at the limit is used as measured.
        push_sample(REQ_VELOCITY,   8'h08, 8'h05, 1'b1, 32'd200003, 1'b0);
        // Zeroing with a good and with a failed read.
        push_sample(REQ_ZERO,       8'h01, 8'h23, 1'b1, 32'd200004, 1'b0);
        push_sample(REQ_ZERO,       8'hAA, 8'h55, 1'b0, 32'd200005, 1'b0);
        // Timestamp at the top of its range, then wrapping around.
        push_sample(REQ_VELOCITY,   8'hF0, 8'h10, 1'b1, 32'hFFFF_FFFF, 1'b0);
        push_sample(REQ_VELOCITY,   8'h00, 8'h09, 1'b1, 32'h0000_0005, 1'b0);
        push_sample(REQ_UPDATE,     8'h5A, 8'hA5, 1'b1, 32'h5555_AAAA, 1'b0);
        gen_raw = 12'hAA5;
        gen_ts  = 32'h5555_AAAA;
        push_random_samples(PHASE_SAMPLES, -1, -1);

        // Limit of zero and fallback of one: every nonzero interval becomes one.
        push_cfg(REG_MAX_INTERVAL, 32'd0);
        push_cfg(REG_FALLBACK, 32'd1);
        push_sample(REQ_VELOCITY, 8'h00, 8'h10, 1'b1, gen_ts, 1'b0);
        push_sample(REQ_VELOCITY, 8'h00, 8'h20, 1'b1, gen_ts, 1'b0);
        push_sample(REQ_VELOCITY, 8'h00, 8'h30, 1'b1, gen_ts + 32'd9, 1'b0);
        gen_raw = 12'h030;
        gen_ts  = gen_ts + 32'd9;
        push_random_samples(PHASE_SAMPLES, -1, -1);

        // Largest values: the measured interval is always used.
        push_cfg(REG_MAX_INTERVAL, 32'hFFFF_FFFF);
        push_cfg(REG_FALLBACK, 32'hFFFF_FFFF);
        push_random_samples(PHASE_SAMPLES, 50, 150);

        // Limit of zero with the longest fallback: tiny rates that truncate.
        push_cfg(REG_MAX_INTERVAL, 32'd0);
        push_random_samples(PHASE_SAMPLES, -1, -1);

        push_cfg(REG_MAX_INTERVAL, $urandom_range(200000, 1));
        push_cfg(REG_FALLBACK, $urandom_range(1000, 1));
        push_random_samples(PHASE_SAMPLES, -1, -1);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (results_seen < samples_queued)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/auv_pkg.sv
rtl/core/auv_unwrap.sv
rtl/core/auv_divider.sv
rtl/core/angle_unwrap_velocity.sv
sim/tb_angle_unwrap_velocity.sv
